// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL; included by command_line_parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/clp_pkg.sv =====
`default_nettype none

package clp_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int CNT_W = $clog2(SLOT_COUNT);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_CMD,
    PH_WAIT1,
    PH_IN1,
    PH_WAIT2,
    PH_IN2,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_CONV,
    SEQ_EMIT
  } seq_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

// ===== src/clp_char_if.sv =====
`default_nettype none

interface clp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

`default_nettype wire

// ===== src/clp_cmd_if.sv =====
`default_nettype none

interface clp_cmd_if;
  logic        valid;
  logic        ready;
  logic [7:0]  command_letter;
  logic [15:0] first_value;
  logic [15:0] second_value;

  modport source (output valid, output command_letter, output first_value,
                  output second_value, input ready);
  modport sink (input valid, input command_letter, input first_value,
                input second_value, output ready);
endinterface

`default_nettype wire

// ===== src/command_line_parser.sv =====
// Command line parser for text received over a serial link.
// The rx channel takes one character per item. Lines have the form
// "C p1 p2" and end with CR or LF. The cmd channel delivers one item per
// finished line whose command letter is not a space: the letter and both
// decimal parameters modulo 65536, zero where a parameter is absent.
// A character that only updates the line state leaves the sequencer idle. A space
// or line end that closes a parameter starts the shared multiply-by-ten
// and add unit, which walks the stored parameter characters slot by slot
// while rx is held off, and a line end then passes through the emit state
// to hand its result to the output register.
// rx is ready only while the sequencer is idle.
// The output register holds one finished command. While it waits, rx
// keeps accepting characters; a line end that must emit a command waits
// until the output register is free, so a stalled receiver eventually
// stalls rx.
// Synchronous reset returns the parser to the start of a line with a
// space as command letter and an empty output register.
`default_nettype none
`include "assert_macros.svh"

module command_line_parser
  import clp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  clp_char_if.sink   rx,
  clp_cmd_if.source  cmd
);

  seq_t             state, state_next;
  phase_t           phase, phase_next;
  logic [7:0]       held_letter, held_letter_next;
  logic [15:0]      held_first, held_first_next;
  logic [15:0]      held_second, held_second_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             in_digits, in_digits_next;
  logic             neg, neg_next;
  logic [15:0]      acc, acc_next;
  logic             target, target_next;
  logic             line_end, line_end_next;
  logic             out_valid, out_valid_next;
  logic             out_load;
  logic [7:0]       out_letter;
  logic [15:0]      out_first;
  logic [15:0]      out_second;

  logic [7:0]       slots [SLOT_COUNT];
  logic             slot_we;
  logic [CNT_W-1:0] slot_waddr;
  logic [7:0]       cur;
  logic [CNT_W-1:0] count_inc;
  logic [15:0]      acc_x10;
  logic [15:0]      conv_value;
  logic             accept;

  assign accept     = rx.valid && rx.ready;
  assign rx.ready   = (state == SEQ_IDLE);
  assign count_inc  = (count == CNT_W'(SLOT_COUNT - 1)) ? '0 : count + 1'b1;
  assign acc_x10    = {acc[12:0], 3'b000} + {acc[14:0], 1'b0};
  assign conv_value = neg ? (16'd0 - acc) : acc;

  assign cmd.valid          = out_valid;
  assign cmd.command_letter = out_letter;
  assign cmd.first_value    = out_first;
  assign cmd.second_value   = out_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= SEQ_IDLE;
      phase       <= PH_CMD;
      held_letter <= CH_SPACE;
      held_first  <= '0;
      held_second <= '0;
      count       <= '0;
      idx         <= '0;
      in_digits   <= 1'b0;
      neg         <= 1'b0;
      acc         <= '0;
      target      <= 1'b0;
      line_end    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      held_letter <= held_letter_next;
      held_first  <= held_first_next;
      held_second <= held_second_next;
      count       <= count_next;
      idx         <= idx_next;
      in_digits   <= in_digits_next;
      neg         <= neg_next;
      acc         <= acc_next;
      target      <= target_next;
      line_end    <= line_end_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slots[slot_waddr] <= rx.rx_char;
    end
  end

  always_ff @(posedge clk) begin
    cur <= slots[idx_next];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_letter <= held_letter;
      out_first  <= held_first;
      out_second <= held_second;
    end
  end

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    held_letter_next = held_letter;
    held_first_next  = held_first;
    held_second_next = held_second;
    count_next       = count;
    idx_next         = idx;
    in_digits_next   = in_digits;
    neg_next         = neg;
    acc_next         = acc;
    target_next      = target;
    line_end_next    = line_end;
    out_valid_next   = out_valid && !cmd.ready;
    out_load         = 1'b0;
    slot_we          = 1'b0;
    slot_waddr       = count;

    unique case (state)
      SEQ_IDLE: begin
        if (accept) begin
          idx_next       = '0;
          in_digits_next = 1'b0;
          neg_next       = 1'b0;
          acc_next       = '0;
          if (rx.rx_char == CH_LF || rx.rx_char == CH_CR) begin
            line_end_next = 1'b1;
            if (phase == PH_IN1 || phase == PH_IN2) begin
              target_next = (phase == PH_IN2);
              state_next  = SEQ_CONV;
            end else begin
              state_next = SEQ_EMIT;
            end
          end else begin
            unique case (phase)
              PH_CMD: begin
                if (rx.rx_char == CH_SPACE) begin
                  phase_next = PH_WAIT1;
                end else begin
                  held_letter_next = rx.rx_char;
                end
              end
              PH_WAIT1, PH_WAIT2: begin
                slot_we    = 1'b1;
                slot_waddr = '0;
                count_next = CNT_W'(1);
                phase_next = (phase == PH_WAIT1) ? PH_IN1 : PH_IN2;
              end
              PH_IN1, PH_IN2: begin
                if (rx.rx_char == CH_SPACE) begin
                  target_next   = (phase == PH_IN2);
                  line_end_next = 1'b0;
                  state_next    = SEQ_CONV;
                  phase_next    = (phase == PH_IN1) ? PH_WAIT2 : PH_SKIP;
                end else begin
                  slot_we    = 1'b1;
                  count_next = count_inc;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      SEQ_CONV: begin
        if (idx == count || (in_digits && !is_digit(cur))) begin
          if (target) begin
            held_second_next = conv_value;
          end else begin
            held_first_next = conv_value;
          end
          state_next = line_end ? SEQ_EMIT : SEQ_IDLE;
        end else if (in_digits) begin
          acc_next = acc_x10 + {12'd0, cur[3:0]};
          idx_next = idx + 1'b1;
        end else if (is_blank(cur)) begin
          idx_next = idx + 1'b1;
        end else if (cur == CH_PLUS || cur == CH_MINUS) begin
          neg_next       = (cur == CH_MINUS);
          idx_next       = idx + 1'b1;
          in_digits_next = 1'b1;
        end else begin
          in_digits_next = 1'b1;
        end
      end

      SEQ_EMIT: begin
        if (held_letter == CH_SPACE || !out_valid || cmd.ready) begin
          if (held_letter != CH_SPACE) begin
            out_load       = 1'b1;
            out_valid_next = 1'b1;
          end
          held_letter_next = CH_SPACE;
          held_first_next  = '0;
          held_second_next = '0;
          phase_next       = PH_CMD;
          state_next       = SEQ_IDLE;
        end
      end

      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

  `ASSERT_IMPLIES(a_conv_in_range, clk, rst, state == SEQ_CONV, idx <= count, "conversion index passed the fill count")
  `ASSERT_IMPLIES(a_no_blank_cmd, clk, rst, out_valid, out_letter != CH_SPACE, "emitted a command with a space letter")
  `ASSERT_NEXT(a_line_end_busy, clk, rst, accept && (rx.rx_char == CH_LF || rx.rx_char == CH_CR), state != SEQ_IDLE, "line end did not start the emit sequence")
  `ASSERT_IMPLIES(a_line_cleared, clk, rst, $past(state == SEQ_EMIT) && state == SEQ_IDLE, held_letter == CH_SPACE && phase == PH_CMD && held_first == 16'd0, "line state not cleared after line end")

endmodule

`default_nettype wire
